/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files of the scale factor block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcsf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcsf: next-cycle check failed");

`endif

/* hw/rtl/pcsf_pkg.sv */
// Package: widths, constants, register codes, types and helpers of the scale factor block.
`timescale 1ns / 1ps

package pcsf_pkg;

	// Field widths
	localparam int TS_W       = 32;
	localparam int P_W        = 32;
	localparam int SF_W       = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TGT_W      = 31;
	localparam int DEV_W      = 16;
	localparam int IVL_W      = 16;

	// Fixed-point constants
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [20:0] M_CAP   = 21'h10_0000;
	localparam logic [19:0] A_CAP   = 20'h8_0000;

	// Register reset values
	localparam logic [31:0]      KAPPA_RST  = 32'd0;
	localparam logic [31:0]      DT_RST     = 32'd65536;
	localparam logic [31:0]      TP_RST     = 32'd65536;
	localparam logic [TGT_W-1:0] TGT_RST    = '0;
	localparam logic [DEV_W-1:0] DEV_RST    = 16'd6554;
	localparam logic [IVL_W-1:0] IVL_RST    = 16'd1;

	// Ratio unit
	localparam int RATIO_W   = 36;
	localparam int DIV_STEPS = 64;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// Cube root pipeline
	localparam int CBRT_STEPS = SF_W;
	localparam int A_W        = 20;
	localparam int X2_W       = 35;
	localparam int REM_W      = A_W + 32;
	localparam int DEL_W      = 56;

	// Interval check pipeline
	localparam int MOD_STAGES = 16;
	localparam int MOD_BITS   = TS_W / MOD_STAGES;

	// Stage bookkeeping: four front stages, the root, one clamp stage
	localparam int FRONT_STAGES = 4;
	localparam int PIPE_DEPTH   = FRONT_STAGES + CBRT_STEPS + 1;
	localparam int APPLY_DLY    = FRONT_STAGES + CBRT_STEPS - MOD_STAGES;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KAPPA,
		REG_DT,
		REG_TP,
		REG_TARGET,
		REG_MAXDEV,
		REG_INTERVAL
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RAT_IDLE,
		RAT_MUL,
		RAT_DIV
	} rat_state_t;

	// Coupling ratio handed from the ratio unit to the datapath
	typedef struct packed {
		logic               busy;
		logic               big;
		logic [RATIO_W-1:0] r;
	} ratio_t;

	// One restoring step of a remainder; rem stays below divisor
	function automatic logic [IVL_W-1:0] mod_step(input logic [IVL_W-1:0] rem,
	                                                input logic bit_in,
	                                                input logic [IVL_W-1:0] divisor);
		logic [IVL_W:0] t;
		t = {rem, bit_in};
		if (t >= {1'b0, divisor}) begin
			t = t - {1'b0, divisor};
		end
		return t[IVL_W-1:0];
	endfunction

endpackage

/* hw/rtl/pcsf_intf.sv */
// Interfaces: input step channel, result channel and register write channel.
`timescale 1ns / 1ps

interface pcsf_in_if;
	import pcsf_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [TS_W-1:0]        timestep_index;
	logic signed [P_W-1:0]  measured_pressure;
	modport source (output valid, timestep_index, measured_pressure, input ready);
	modport sink (input valid, timestep_index, measured_pressure, output ready);
endinterface

interface pcsf_out_if;
	import pcsf_pkg::*;
	logic            valid;
	logic            ready;
	logic            apply_scaling;
	logic [SF_W-1:0] scale_factor;
	logic            clamped_low;
	logic            clamped_high;
	logic            invalid_argument;
	modport source (output valid, apply_scaling, scale_factor, clamped_low, clamped_high,
		invalid_argument, input ready);
	modport sink (input valid, apply_scaling, scale_factor, clamped_low, clamped_high,
		invalid_argument, output ready);
endinterface

interface pcsf_cfg_if;
	import pcsf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/pcsf_ratio.sv */
// Ratio unit: forms floor(floor(K*D/2^16)*2^16/T) with a multiply and a 64-step divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcsf_ratio (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      kappa,
	input  logic [31:0]      dt,
	input  logic [31:0]      tp,
	output pcsf_pkg::ratio_t ratio
);
	import pcsf_pkg::*;

	rat_state_t         state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [63:0]        num_q;
	logic [31:0]        rem_q;
	logic [RATIO_W-1:0] r_q;
	logic               big_q;

	logic [31:0] tp_eff;
	logic [63:0] prod;
	logic [32:0] trial;
	logic [32:0] rem_nx;
	logic        ge;
	logic        div_last;
	logic [63:0] quot;

	// Divider step: zero relax time counts as one LSB
	always_comb begin
		tp_eff   = (tp == '0) ? 32'd1 : tp;
		prod     = 64'(kappa) * 64'(dt);
		trial    = {rem_q, num_q[63]};
		ge       = trial >= {1'b0, tp_eff};
		rem_nx   = ge ? (trial - {1'b0, tp_eff}) : trial;
		div_last = cnt_q == CNT_W'(DIV_STEPS - 1);
		quot     = {num_q[62:0], ge};
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RAT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and outputs; a new write restarts the sequence
	always_comb begin
		state_d = state_q;
		case (state_q)
			RAT_IDLE: begin
				state_d = RAT_IDLE;
			end
			RAT_MUL: begin
				state_d = RAT_DIV;
			end
			RAT_DIV: begin
				if (div_last) begin
					state_d = RAT_IDLE;
				end
			end
			default: begin
				state_d = RAT_IDLE;
			end
		endcase
		if (start) begin
			state_d = RAT_MUL;
		end
		ratio.busy = state_q != RAT_IDLE;
		ratio.big  = big_q;
		ratio.r    = r_q;
	end

	// Step counter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			r_q   <= '0;
			big_q <= 1'b0;
		end else begin
			case (state_q)
				RAT_MUL: begin
					cnt_q <= '0;
				end
				RAT_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (div_last) begin
						big_q <= |quot[63:RATIO_W];
						r_q   <= quot[RATIO_W-1:0];
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// Dividend/quotient shifter and partial remainder
	always_ff @(posedge clk) begin
		case (state_q)
			RAT_MUL: begin
				num_q <= {prod[63:16], 16'b0};
				rem_q <= '0;
			end
			RAT_DIV: begin
				num_q <= quot;
				rem_q <= rem_nx[31:0];
			end
			default: begin
				num_q <= num_q;
				rem_q <= rem_q;
			end
		endcase
	end

	`PCSF_ASSERT_IMPL(a_rem_below_div, clk, arst_n, state_q == RAT_DIV, rem_q < tp_eff)
	`PCSF_ASSERT_NEXT(a_start_mul, clk, arst_n, start, state_q == RAT_MUL)
	`PCSF_ASSERT_NEXT(a_div_done, clk, arst_n, state_q == RAT_DIV && div_last && !start, state_q == RAT_IDLE)

endmodule

/* hw/rtl/pcsf_cbrt_pipe.sv */
// Cube root pipeline: floor(cbrt(a * 2^32)), one result bit per stage.
`timescale 1ns / 1ps

module pcsf_cbrt_pipe (
	input  logic                       clk,
	input  logic                       en,
	input  logic [pcsf_pkg::A_W-1:0]   a_in,
	output logic [pcsf_pkg::SF_W-1:0]  x_out
);
	import pcsf_pkg::*;

	// Per stage: root so far, its square, and goal minus its cube
	logic [SF_W-1:0]  x_s   [CBRT_STEPS];
	logic [X2_W-1:0]  x2_s  [CBRT_STEPS];
	logic [REM_W-1:0] rem_s [CBRT_STEPS];

	for (genvar j = 0; j < CBRT_STEPS; j++) begin : g_step
		localparam int B = CBRT_STEPS - 1 - j;

		logic [SF_W-1:0]  x_in;
		logic [X2_W-1:0]  x2_in;
		logic [REM_W-1:0] rem_in;
		logic [DEL_W-1:0] delta;
		logic             take;

		if (j == 0) begin : g_first
			assign x_in   = '0;
			assign x2_in  = '0;
			assign rem_in = {a_in, 32'b0};
		end else begin : g_next
			assign x_in   = x_s[j-1];
			assign x2_in  = x2_s[j-1];
			assign rem_in = rem_s[j-1];
		end

		// (x + 2^B)^3 - x^3 = 3x^2 2^B + 3x 2^2B + 2^3B
		always_comb begin
			delta = ((((DEL_W'(x2_in)) << 1) + DEL_W'(x2_in)) << B)
				+ ((((DEL_W'(x_in)) << 1) + DEL_W'(x_in)) << (2 * B))
				+ (DEL_W'(1) << (3 * B));
			take  = delta <= DEL_W'(rem_in);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (take) begin
					x_s[j]   <= x_in | (SF_W'(1) << B);
					x2_s[j]  <= x2_in + (X2_W'(x_in) << (B + 1)) + (X2_W'(1) << (2 * B));
					rem_s[j] <= rem_in - delta[REM_W-1:0];
				end else begin
					x_s[j]   <= x_in;
					x2_s[j]  <= x2_in;
					rem_s[j] <= rem_in;
				end
			end
		end
	end

	assign x_out = x_s[CBRT_STEPS-1];

endmodule

/* hw/rtl/pressure_coupling_scale_factor.sv */
// Top level: pressure coupling scale factor pipeline with register file.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one timestep beat per clock while no ratio update runs; the whole pipeline holds
// while a finished result waits on the result channel. Every stage takes a new beat each
// cycle that the pipeline advances, and a beat passes through 23 register stages: four
// front stages (pressure difference, two 18x32 partial products, saturation, cube-root
// argument), eighteen cube-root stages of one result bit each, and a clamp stage that is
// also the output register; the interval check runs beside them as a 16-stage remainder
// pipeline, two timestep bits per stage. Writing coupling_kappa, time_step_len or
// relax_time starts a ratio update (a multiply, then the 64 divider steps) during
// which no timestep beat is taken; register writes themselves are always taken at once.
module pressure_coupling_scale_factor (
	input  logic       clk,
	input  logic       arst_n,
	pcsf_in_if.sink    item,
	pcsf_out_if.source result,
	pcsf_cfg_if.sink   cfg
);
	import pcsf_pkg::*;

	// Register file
	logic [31:0]      kappa_q;
	logic [31:0]      dt_q;
	logic [31:0]      tp_q;
	logic [TGT_W-1:0] target_q;
	logic [DEV_W-1:0] maxdev_q;
	logic [IVL_W-1:0] ivl_q;

	logic     cfg_wr;
	cfg_idx_t cfg_sel;
	logic     ratio_start;
	ratio_t   ratio;

	assign cfg.ready   = 1'b1;
	assign cfg_wr      = cfg.valid && cfg.ready;
	assign cfg_sel     = cfg_idx_t'(cfg.index);
	assign ratio_start = cfg_wr && (cfg_sel == REG_KAPPA || cfg_sel == REG_DT
		|| cfg_sel == REG_TP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kappa_q  <= KAPPA_RST;
			dt_q     <= DT_RST;
			tp_q     <= TP_RST;
			target_q <= TGT_RST;
			maxdev_q <= DEV_RST;
			ivl_q    <= IVL_RST;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_KAPPA:    kappa_q  <= cfg.data;
				REG_DT:       dt_q     <= cfg.data;
				REG_TP:       tp_q     <= cfg.data;
				REG_TARGET:   target_q <= cfg.data[TGT_W-1:0];
				REG_MAXDEV:   maxdev_q <= cfg.data[DEV_W-1:0];
				REG_INTERVAL: ivl_q    <= cfg.data[IVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pcsf_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ratio_start),
		.kappa  (kappa_q),
		.dt     (dt_q),
		.tp     (tp_q),
		.ratio  (ratio)
	);

	// Global advance: everything shifts unless the output beat is stuck
	logic                  en;
	logic                  accept;
	logic [PIPE_DEPTH:1]   vld_s;

	assign en         = !vld_s[PIPE_DEPTH] || result.ready;
	assign item.ready = en && !ratio.busy;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_DEPTH-1:1], accept};
		end
	end

	// Stage 1: |target - measured| and sign
	logic signed [32:0] diff;
	logic [31:0]        ad_s1;
	logic               pos_s1;

	assign diff = $signed({2'b00, target_q})
		- $signed({item.measured_pressure[P_W-1], item.measured_pressure});

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s1  <= diff[32] ? 32'(-diff) : diff[31:0];
			pos_s1 <= !diff[32] && (diff != '0);
		end
	end

	// Stage 2: ratio times difference as two partial products
	logic [49:0] pp_hi_s2;
	logic [49:0] pp_lo_s2;
	logic        pos_s2;
	logic        sat_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_hi_s2 <= 50'(ratio.r[RATIO_W-1:18]) * 50'(ad_s1);
			pp_lo_s2 <= 50'(ratio.r[17:0]) * 50'(ad_s1);
			pos_s2   <= pos_s1;
			sat_s2   <= ratio.big && (ad_s1 != '0);
		end
	end

	// Stage 3: sum, drop 16 fraction bits, cap at 16.0
	logic [67:0] prod_sum;
	logic [20:0] m_s3;
	logic        pos_s3;

	assign prod_sum = {pp_hi_s2, 18'b0} + 68'(pp_lo_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3   <= (sat_s2 || prod_sum[67:36] != '0) ? M_CAP : {1'b0, prod_sum[35:16]};
			pos_s3 <= pos_s2;
		end
	end

	// Stage 4: cube-root argument, capped at 8.0; non-positive is flagged
	logic [21:0]    a_wide;
	logic           inv_nx;
	logic [A_W-1:0] a_s4;
	logic           inv_s4;

	always_comb begin
		a_wide = pos_s3 ? (22'(ONE_Q16) - 22'(m_s3)) : (22'(ONE_Q16) + 22'(m_s3));
		inv_nx = pos_s3 && (m_s3 >= 21'(ONE_Q16));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4   <= inv_nx ? '0 : ((a_wide > 22'(A_CAP)) ? A_CAP : a_wide[A_W-1:0]);
			inv_s4 <= inv_nx;
		end
	end

	// Stages 5 to 22: cube root
	logic [SF_W-1:0] root;

	pcsf_cbrt_pipe u_cbrt (
		.clk   (clk),
		.en    (en),
		.a_in  (a_s4),
		.x_out (root)
	);

	logic inv_dly_s [CBRT_STEPS];

	for (genvar k = 0; k < CBRT_STEPS; k++) begin : g_inv
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					inv_dly_s[k] <= inv_s4;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					inv_dly_s[k] <= inv_dly_s[k-1];
				end
			end
		end
	end

	// Stages 1 to 16: timestep remainder by the interval, two bits a stage
	logic [IVL_W-1:0] ivl_eff;
	logic [IVL_W-1:0] mod_rem_s [MOD_STAGES];
	logic [TS_W-1:0]  mod_ts_s  [MOD_STAGES];

	assign ivl_eff = (ivl_q == '0) ? IVL_W'(1) : ivl_q;

	for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
		logic [IVL_W-1:0] rem_in;
		logic [IVL_W-1:0] rem_out;
		logic [TS_W-1:0]  ts_in;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign ts_in  = item.timestep_index;
		end else begin : g_next
			assign rem_in = mod_rem_s[k-1];
			assign ts_in  = mod_ts_s[k-1];
		end

		always_comb begin
			rem_out = rem_in;
			for (int i = 0; i < MOD_BITS; i++) begin
				rem_out = mod_step(rem_out, ts_in[TS_W-1-i], ivl_eff);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mod_rem_s[k] <= rem_out;
				mod_ts_s[k]  <= ts_in << MOD_BITS;
			end
		end
	end

	// Stages 17 to 22: carry the on-interval flag to the clamp stage
	logic apply_dly_s [APPLY_DLY];

	for (genvar k = 0; k < APPLY_DLY; k++) begin : g_apply
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					apply_dly_s[k] <= mod_rem_s[MOD_STAGES-1] == '0;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					apply_dly_s[k] <= apply_dly_s[k-1];
				end
			end
		end
	end

	// Stage 23: clamp to [1 - X, 1 + X]; this is the output register
	logic [16:0]     lo_bound;
	logic [SF_W-1:0] hi_bound;
	logic            apply_s23;
	logic [SF_W-1:0] sf_s23;
	logic            clo_s23;
	logic            chi_s23;
	logic            inv_s23;

	assign lo_bound = ONE_Q16 - 17'(maxdev_q);
	assign hi_bound = SF_W'(ONE_Q16) + SF_W'(maxdev_q);

	always_ff @(posedge clk) begin
		if (en) begin
			apply_s23 <= apply_dly_s[APPLY_DLY-1];
			sf_s23    <= '0;
			clo_s23   <= 1'b0;
			chi_s23   <= 1'b0;
			inv_s23   <= 1'b0;
			if (apply_dly_s[APPLY_DLY-1]) begin
				if (inv_dly_s[CBRT_STEPS-1]) begin
					sf_s23  <= SF_W'(lo_bound);
					clo_s23 <= 1'b1;
					inv_s23 <= 1'b1;
				end else if (root < SF_W'(lo_bound)) begin
					sf_s23  <= SF_W'(lo_bound);
					clo_s23 <= 1'b1;
				end else if (root > hi_bound) begin
					sf_s23  <= hi_bound;
					chi_s23 <= 1'b1;
				end else begin
					sf_s23  <= root;
				end
			end
		end
	end

	assign result.valid            = vld_s[PIPE_DEPTH];
	assign result.apply_scaling    = apply_s23;
	assign result.scale_factor     = sf_s23;
	assign result.clamped_low      = clo_s23;
	assign result.clamped_high     = chi_s23;
	assign result.invalid_argument = inv_s23;

	// Checks on the output beat
	logic skip_clean;
	logic in_bounds;
	logic inv_at_low;

	assign skip_clean = result.scale_factor == '0 && !result.clamped_low
		&& !result.clamped_high && !result.invalid_argument;
	assign in_bounds  = result.scale_factor >= SF_W'(lo_bound)
		&& result.scale_factor <= hi_bound;
	assign inv_at_low = result.clamped_low && result.scale_factor == SF_W'(lo_bound);

	`PCSF_ASSERT_IMPL(a_skip_zero, clk, arst_n, result.valid && !result.apply_scaling, skip_clean)
	`PCSF_ASSERT_IMPL(a_in_bounds, clk, arst_n, result.valid && result.apply_scaling, in_bounds)
	`PCSF_ASSERT_IMPL(a_invalid_low, clk, arst_n, result.valid && result.invalid_argument, inv_at_low)

endmodule

/* sim/pressure_coupling_scale_factor_tb.sv */
// Testbench: pressure coupling scale factor, directed table then random steps vs. predictor.
`timescale 1ns / 1ps

module pressure_coupling_scale_factor_tb;
	import pcsf_pkg::*;

	// Result beat as the predictor sees it
	typedef struct packed {
		logic            apply_scaling;
		logic [SF_W-1:0] scale_factor;
		logic            clamped_low;
		logic            clamped_high;
		logic            invalid_argument;
	} scale_result_t;

	typedef enum logic {ROW_STEP, ROW_WRITE} row_kind_t;

	// One line of the directed table: a register write or a timestep
	typedef struct {
		row_kind_t                 kind;
		logic [CFG_IDX_W-1:0]      idx;
		logic [31:0]               word;
		logic [31:0]               pres;
		bit                        typed;
		scale_result_t             want;
	} plan_row_t;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam longint UNITY_Q16 = 65536;
	localparam logic [63:0] M_SAT = 64'd1 << 20;
	localparam longint ARG_CEIL = 524288;
	localparam scale_result_t AT_UNITY = '{apply_scaling: 1'b1, scale_factor: 18'd65536,
		default: '0};
	localparam scale_result_t SKIPPED = '0;

	logic clk;
	logic arst_n;

	pcsf_in_if  item_ch ();
	pcsf_out_if res_ch ();
	pcsf_cfg_if cfg_ch ();

	pressure_coupling_scale_factor uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Shadow of the register file, at reset values
	logic [31:0]      kappa_reg  = 32'd0;
	logic [31:0]      step_reg   = 32'd65536;
	logic [31:0]      tau_reg    = 32'd65536;
	logic [TGT_W-1:0] target_reg = '0;
	logic [DEV_W-1:0] dev_reg    = 16'd6554;
	logic [IVL_W-1:0] period_reg = 16'd1;

	scale_result_t factor_q [$];
	int            fault_count = 0;
	int            beat_count = 0;
	bit            quiet = 1'b0;
	bit            step_typed = 1'b0;
	scale_result_t step_want = '0;
	plan_row_t     step_plan [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("pressure_coupling_scale_factor regression: fail");
		$finish;
	end

	task automatic flag_fault(input string msg);
		$display("[%0t] result beat %0d: %s", $realtime, beat_count, msg);
		fault_count++;
	endtask

	// Expected result of one timestep under the current register shadow
	function automatic scale_result_t predict_scaling(input logic [31:0] ts,
	                                                  input logic [31:0] raw);
		scale_result_t     res;
		logic [31:0]       period;
		logic [31:0]       tau;
		logic [63:0]       kd;
		logic [63:0]       ratio;
		logic [63:0]       mag;
		logic [63:0]       m;
		logic [127:0]      prod;
		logic signed [63:0] meas;
		logic signed [63:0] diff;
		logic signed [63:0] arg;
		logic [63:0]       goal;
		logic [63:0]       root;
		logic [63:0]       trial;
		logic [SF_W-1:0]   lo_b;
		logic [SF_W-1:0]   hi_b;
		res = '0;
		period = (period_reg == '0) ? 32'd1 : {16'd0, period_reg};
		if (ts % period != 32'd0)
			return res;
		tau = (tau_reg == 32'd0) ? 32'd1 : tau_reg;
		meas = {{32{raw[31]}}, raw};
		diff = $signed({33'd0, target_reg}) - meas;
		mag = (diff < 0) ? -diff : diff;
		kd = {32'd0, kappa_reg} * {32'd0, step_reg};
		ratio = {kd[63:16], 16'd0} / {32'd0, tau};
		prod = {64'd0, ratio} * {64'd0, mag};
		// product beyond 64 bits saturates like an oversized one
		if (prod[127:64] != '0) begin
			m = M_SAT;
		end else begin
			m = {16'd0, prod[63:16]};
			if (m > M_SAT)
				m = M_SAT;
		end
		arg = (diff > 0) ? UNITY_Q16 - $signed(m) : UNITY_Q16 + $signed(m);
		lo_b = 18'd65536 - {2'd0, dev_reg};
		hi_b = 18'd65536 + {2'd0, dev_reg};
		res.apply_scaling = 1'b1;
		if (arg <= 0) begin
			res.scale_factor = lo_b;
			res.clamped_low = 1'b1;
			res.invalid_argument = 1'b1;
			return res;
		end
		if (arg > ARG_CEIL)
			arg = ARG_CEIL;
		// bitwise floor of the cube root of arg * 2^32
		goal = {arg[31:0], 32'd0};
		root = '0;
		for (int b = SF_W - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial * trial <= goal)
				root = trial;
		end
		if (root < {46'd0, lo_b}) begin
			root = {46'd0, lo_b};
			res.clamped_low = 1'b1;
		end
		if (root > {46'd0, hi_b}) begin
			root = {46'd0, hi_b};
			res.clamped_high = 1'b1;
		end
		res.scale_factor = root[SF_W-1:0];
		return res;
	endfunction

	// Table row builders
	function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
	                                      input logic [31:0] value);
		plan_row_t row;
		row = '{kind: ROW_WRITE, idx: idx, word: value, pres: '0, typed: 1'b0, want: '0};
		return row;
	endfunction

	function automatic plan_row_t step_row(input logic [31:0] ts, input logic [31:0] p);
		plan_row_t row;
		row = '{kind: ROW_STEP, idx: '0, word: ts, pres: p, typed: 1'b0, want: '0};
		return row;
	endfunction

	function automatic plan_row_t step_row_is(input logic [31:0] ts, input logic [31:0] p,
	                                          input scale_result_t want);
		plan_row_t row;
		row = '{kind: ROW_STEP, idx: '0, word: ts, pres: p, typed: 1'b1, want: want};
		return row;
	endfunction

	function automatic scale_result_t factor_is(input logic [SF_W-1:0] sf, input bit clo,
	                                            input bit chi, input bit inv);
		scale_result_t res;
		res = '{apply_scaling: 1'b1, scale_factor: sf, clamped_low: clo, clamped_high: chi,
			invalid_argument: inv};
		return res;
	endfunction

	// Random register value, extremes included
	function automatic logic [31:0] pick_reg(input cfg_idx_t which);
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 32'd0;
		if (roll == 1)
			return 32'hFFFF_FFFF;
		if (roll == 2)
			return $urandom;
		case (which)
			REG_KAPPA, REG_DT: return $urandom_range(1, 32'h2_0000);
			REG_TP: return $urandom_range(1, 32'h4_0000);
			REG_TARGET: return $urandom_range(0, 32'h20_0000);
			REG_MAXDEV: return (roll < 6) ? 32'd6554 : $urandom_range(1, 32'h8000);
			default: return (roll < 6) ? 32'd1 : $urandom_range(2, 9);
		endcase
	endfunction

	// Entered and left at a falling edge
	task automatic send_step(input logic [31:0] ts, input logic [31:0] p, input bit typed,
	                         input scale_result_t want);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		step_typed = typed;
		step_want = want;
		item_ch.valid <= 1'b1;
		item_ch.timestep_index <= ts;
		item_ch.measured_pressure <= p;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (factor_q.size() != 0);
	endtask

	task automatic compare_factor(input scale_result_t got, input scale_result_t want);
		if (got.apply_scaling !== want.apply_scaling)
			flag_fault($sformatf("apply_scaling %0b, expected %0b",
				got.apply_scaling, want.apply_scaling));
		if (got.scale_factor !== want.scale_factor)
			flag_fault($sformatf("scale_factor %0d, expected %0d",
				got.scale_factor, want.scale_factor));
		if (got.clamped_low !== want.clamped_low)
			flag_fault($sformatf("clamped_low %0b, expected %0b",
				got.clamped_low, want.clamped_low));
		if (got.clamped_high !== want.clamped_high)
			flag_fault($sformatf("clamped_high %0b, expected %0b",
				got.clamped_high, want.clamped_high));
		if (got.invalid_argument !== want.invalid_argument)
			flag_fault($sformatf("invalid_argument %0b, expected %0b",
				got.invalid_argument, want.invalid_argument));
	endtask

	// Beat monitor: register writes, accepted steps, returned results
	always @(posedge clk) begin
		scale_result_t got;
		scale_result_t want;
		if (arst_n === 1'b1) begin
			if (res_ch.valid && res_ch.ready) begin
				beat_count++;
				got = '{apply_scaling: res_ch.apply_scaling, scale_factor: res_ch.scale_factor,
					clamped_low: res_ch.clamped_low, clamped_high: res_ch.clamped_high,
					invalid_argument: res_ch.invalid_argument};
				if (factor_q.size() == 0) begin
					flag_fault("result beat with nothing outstanding");
				end else begin
					want = factor_q.pop_front();
					compare_factor(got, want);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_KAPPA: kappa_reg = cfg_ch.data;
					REG_DT: step_reg = cfg_ch.data;
					REG_TP: tau_reg = cfg_ch.data;
					REG_TARGET: target_reg = cfg_ch.data[TGT_W-1:0];
					REG_MAXDEV: dev_reg = cfg_ch.data[DEV_W-1:0];
					REG_INTERVAL: period_reg = cfg_ch.data[IVL_W-1:0];
					default: ;
				endcase
			end
			if (item_ch.valid && item_ch.ready) begin
				if (step_typed)
					factor_q.insert(factor_q.size(), step_want);
				else
					factor_q.insert(factor_q.size(), predict_scaling(item_ch.timestep_index,
						item_ch.measured_pressure));
			end
		end
	end

	// Result side back-pressure in bursts
	initial begin
		int stall;
		stall = 0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				res_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(0, 16);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [31:0] ts;
		logic [31:0] ts_next;
		logic [31:0] p;
		logic [31:0] period;
		logic [31:0] delta;
		logic [31:0] fill;
		int          shift;
		bit          extreme;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.timestep_index <= '0;
		item_ch.measured_pressure <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		ts_next = '0;

		step_plan = '{
			// reset settings: ratio zero, factor exactly one
			step_row_is(32'd0, 32'd0, AT_UNITY),
			step_row_is(32'hFFFF_FFFF, 32'h7FFF_FFFF, AT_UNITY),
			step_row_is(32'd12345, 32'h8000_0000, AT_UNITY),
			// unit ratio; +1.0 measured gives argument 2.0, clamps high
			reg_row(REG_KAPPA, 32'h0001_0000),
			step_row_is(32'd7, 32'h0001_0000, factor_is(18'd72090, 0, 1, 0)),
			// argument exactly zero, then negative, then saturated product
			step_row_is(32'd8, 32'hFFFF_0000, factor_is(18'd58982, 1, 0, 1)),
			step_row_is(32'd9, 32'hFFFE_0000, factor_is(18'd58982, 1, 0, 1)),
			step_row_is(32'd10, 32'h8000_0000, factor_is(18'd58982, 1, 0, 1)),
			// argument capped at 8.0
			step_row_is(32'd11, 32'h7FFF_FFFF, factor_is(18'd72090, 0, 1, 0)),
			step_row(32'd12, 32'h0000_0100),
			// widest deviation: bounds 1 LSB and just under 2.0
			reg_row(REG_MAXDEV, 32'h0000_FFFF),
			step_row_is(32'd13, 32'h7FFF_FFFF, factor_is(18'd131071, 0, 1, 0)),
			step_row_is(32'd14, 32'h8000_0000, factor_is(18'd1, 1, 0, 1)),
			step_row(32'd15, 32'hFFFF_8000),
			// zero deviation pins both bounds at one
			reg_row(REG_MAXDEV, 32'd0),
			step_row_is(32'd16, 32'h0003_0000, factor_is(18'd65536, 0, 1, 0)),
			step_row_is(32'd17, 32'd0, AT_UNITY),
			step_row_is(32'd18, 32'hFFFF_0000, factor_is(18'd65536, 1, 0, 1)),
			// zero interval acts as one; then the widest interval
			reg_row(REG_INTERVAL, 32'd0),
			step_row_is(32'd3, 32'd0, AT_UNITY),
			reg_row(REG_INTERVAL, 32'h0000_FFFF),
			step_row_is(32'd65534, 32'd0, SKIPPED),
			step_row_is(32'hFFFF_FFFF, 32'd0, AT_UNITY), // 65535 * 65537
			step_row_is(32'hFFFF_FFFE, 32'h7FFF_FFFF, SKIPPED),
			// zero relax time counts as one LSB
			reg_row(REG_INTERVAL, 32'd1),
			reg_row(REG_MAXDEV, 32'd6554),
			reg_row(REG_TP, 32'd0),
			step_row(32'd19, 32'h0000_0001),
			reg_row(REG_KAPPA, 32'hFFFF_FFFF),
			reg_row(REG_DT, 32'hFFFF_FFFF),
			step_row_is(32'd20, 32'hFFFF_FFFF, factor_is(18'd58982, 1, 0, 1)),
			// zero time step zeroes the ratio
			reg_row(REG_DT, 32'd0),
			step_row_is(32'd21, 32'h8000_0000, AT_UNITY),
			// one-LSB ratio with the largest target
			reg_row(REG_KAPPA, 32'h0001_0000),
			reg_row(REG_DT, 32'h0001_0000),
			reg_row(REG_TP, 32'hFFFF_FFFF),
			reg_row(REG_TARGET, 32'h7FFF_FFFF),
			step_row(32'd22, 32'h8000_0000),
			// unused indexes leave the registers alone
			reg_row(REG_SPARE_LO, 32'd0),
			reg_row(REG_SPARE_HI, 32'hFFFF_FFFF),
			step_row_is(32'd23, 32'h7FFF_FFFF, AT_UNITY)
		};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (step_plan[i]) begin
			if (step_plan[i].kind == ROW_WRITE) begin
				drain();
				write_reg(step_plan[i].idx, step_plan[i].word);
			end else begin
				send_step(step_plan[i].word, step_plan[i].pres, step_plan[i].typed,
					step_plan[i].want);
			end
		end

		// random phases, each under fresh register settings
		for (int ph = 0; ph < 14; ph++) begin
			drain();
			quiet = (ph % 4 == 3) || (ph == 13);
			extreme = (ph == 1) || (ph == 2);
			fill = (ph == 1) ? 32'hFFFF_FFFF : 32'd0;
			write_reg(REG_KAPPA, extreme ? fill : pick_reg(REG_KAPPA));
			write_reg(REG_DT, extreme ? fill : pick_reg(REG_DT));
			write_reg(REG_TP, extreme ? fill : pick_reg(REG_TP));
			write_reg(REG_TARGET, extreme ? fill : pick_reg(REG_TARGET));
			write_reg(REG_MAXDEV, extreme ? fill : pick_reg(REG_MAXDEV));
			write_reg(REG_INTERVAL, extreme ? fill : pick_reg(REG_INTERVAL));
			period = (period_reg == '0) ? 32'd1 : {16'd0, period_reg};
			for (int n = 0; n < 125; n++) begin
				// mostly consecutive steps, some on the interval, some anywhere
				case ($urandom_range(0, 3))
					0, 1: ts = ts_next;
					2: ts = $urandom_range(0, 32'hFFFF_FFFF / period) * period;
					default: ts = $urandom;
				endcase
				ts_next = ts + 32'd1;
				// pressure near the target at a random scale, plus wide values
				shift = $urandom_range(0, 32);
				delta = $urandom & 32'((64'd1 << shift) - 64'd1);
				case ($urandom_range(0, 9))
					0, 1: p = $urandom;
					2: p = {1'b0, target_reg};
					3: p = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
					default: p = $urandom_range(0, 1) ? {1'b0, target_reg} + delta
						: {1'b0, target_reg} - delta;
				endcase
				send_step(ts, p, 1'b0, '0);
				// hold off until the pipeline has emptied
				if (n == 62 && ph % 3 == 0)
					drain();
			end
		end

		drain();
		repeat (40) @(negedge clk);
		if (fault_count == 0)
			$display("pressure_coupling_scale_factor regression: pass");
		else
			$display("pressure_coupling_scale_factor regression: fail");
		$finish;
	end

endmodule
